// ----- design/iee_pkg.sv -----
// Shared types and codes for the infix integer expression evaluator.
`default_nettype none
package iee_pkg;

  // Operator that follows each operand
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4
  } op_t;

  // Multiplicative operation waiting for its right operand
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_MUL  = 2'd1,
    PEND_DIV  = 2'd2
  } pend_t;

  // Request from the sequencer to the shared arithmetic unit
  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

endpackage
`default_nettype wire

// ----- design/iee_alu.sv -----
// Shared iterative multiply / divide unit: one adder, one bit per cycle.
`default_nettype none
module iee_alu #(
  parameter int W = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire iee_pkg::alu_req_t req,
  input  wire logic [W-1:0]    a,
  input  wire logic [W-1:0]    b,
  output logic                 done,
  output logic [W-1:0]         y
);
  import iee_pkg::*;

  localparam int CW = $clog2(W);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_RUN  = 3'b010,
    A_FIX  = 3'b100
  } alu_state_t;

  alu_state_t    state;
  logic [CW-1:0] cnt;
  logic          is_div;
  logic          neg_q;
  logic          b_zero;
  logic [W-1:0]  a_hold;
  // acc / remainder, multiplicand / divisor magnitude, multiplier / quotient
  logic [W-1:0]  reg_a;
  logic [W-1:0]  reg_b;
  logic [W-1:0]  reg_c;

  logic [W:0]    shifted;
  logic [W:0]    add_a;
  logic [W:0]    add_b;
  logic          add_cin;
  logic [W:0]    sum;
  logic [W-1:0]  a_mag;
  logic [W-1:0]  b_mag;

  // Magnitudes for the divide path
  assign a_mag = a[W-1] ? (~a) + W'(1) : a;
  assign b_mag = b[W-1] ? (~b) + W'(1) : b;

  // The single shared adder
  assign shifted = {reg_a, reg_c[W-1]};
  always_comb begin
    if (is_div) begin
      add_a   = shifted;
      add_b   = ~{1'b0, reg_b};
      add_cin = 1'b1;
    end else begin
      add_a   = {1'b0, reg_a};
      add_b   = reg_c[0] ? {1'b0, reg_b} : '0;
      add_cin = 1'b0;
    end
  end
  assign sum = add_a + add_b + {{W{1'b0}}, add_cin};

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            state  <= A_RUN;
            cnt    <= CW'(W - 1);
            is_div <= req.is_div;
            a_hold <= a;
            b_zero <= (b == '0);
            neg_q  <= a[W-1] ^ b[W-1];
            reg_a  <= '0;
            if (req.is_div) begin
              reg_b <= b_mag;
              reg_c <= a_mag;
            end else begin
              reg_b <= a;
              reg_c <= b;
            end
          end
        end
        A_RUN: begin
          if (is_div) begin
            if (!sum[W]) begin
              reg_a <= sum[W-1:0];
              reg_c <= {reg_c[W-2:0], 1'b1};
            end else begin
              reg_a <= shifted[W-1:0];
              reg_c <= {reg_c[W-2:0], 1'b0};
            end
          end else begin
            reg_a <= sum[W-1:0];
            reg_b <= {reg_b[W-2:0], 1'b0};
            reg_c <= {1'b0, reg_c[W-1:1]};
          end
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  // Sign fix and divide-by-zero pass-through
  always_comb begin
    if (!is_div) begin
      y = reg_a;
    end else if (b_zero) begin
      y = a_hold;
    end else if (neg_q) begin
      y = (~reg_c) + W'(1);
    end else begin
      y = reg_c;
    end
  end

  assign done = (state == A_FIX);

endmodule
`default_nettype wire

// ----- design/infix_integer_expression_evaluator.sv -----
// Top level: sequencer, expression state and stream ports.
//
// Channel | Direction | Contents
// s_*     | in        | tdata: operand; tuser: operation (0 +, 1 -, 2 *, 3 /, 4 =)
// m_*     | out       | tdata: result, one word per '=' item
//
// An item whose left side has no pending * or / goes from its accept through
// a start step and a commit step back to idle. With a pending * or / it also
// waits in a busy step while the shared adder in the multiply / divide unit
// settles one bit per cycle. Ready stays low while an item is worked on, and
// an '=' item waits in the last step while the output word is still not taken.
// Reset (rst, synchronous) clears the expression state and the output word.
`default_nettype none
module infix_integer_expression_evaluator #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // [DATA_WIDTH-1:0] operand, zero padded to whole bytes
  input  wire logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // [2:0] operation
  input  wire logic [2:0]                            s_tuser,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // [DATA_WIDTH-1:0] result, zero padded to whole bytes
  output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]    m_tdata
);
  import iee_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int PW = ((DATA_WIDTH + 7) / 8) * 8;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_START  = 4'b0010,
    S_BUSY   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t       state;
  logic [W-1:0] x_reg;
  logic [2:0]   op_reg;
  logic [W-1:0] t_reg;
  logic [W-1:0] running_sum;
  logic         add_neg;
  logic [W-1:0] product_term;
  pend_t        pend;
  logic [W-1:0] out_data;
  logic         out_valid;

  alu_req_t     alu_req;
  logic         alu_done;
  logic [W-1:0] alu_y;
  logic         op_ok;
  logic         op_term;
  logic         out_free;
  logic         emit;
  logic [W-1:0] sum_next;

  assign op_ok    = (op_reg <= OP_EQ);
  assign op_term  = (op_reg == OP_MUL) || (op_reg == OP_DIV);
  assign out_free = !out_valid || m_tready;
  assign sum_next = add_neg ? running_sum - t_reg : running_sum + t_reg;
  assign emit     = (state == S_COMMIT) && (op_reg == OP_EQ) && out_free;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = PW'(out_data);

  // Start the shared unit when a * or / is waiting for this operand
  assign alu_req.start  = (state == S_START) && op_ok
                          && ((pend == PEND_MUL) || (pend == PEND_DIV));
  assign alu_req.is_div = (pend == PEND_DIV);

  iee_alu #(
    .W (W)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (product_term),
    .b    (x_reg),
    .done (alu_done),
    .y    (alu_y)
  );

  // Output word register: load on '=', drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_data  <= '0;
    end else if (emit) begin
      out_valid <= 1'b1;
      out_data  <= sum_next;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_sum  <= '0;
      add_neg      <= 1'b0;
      product_term <= '0;
      pend         <= PEND_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            x_reg  <= s_tdata[W-1:0];
            op_reg <= s_tuser;
            state  <= S_START;
          end
        end
        S_START: begin
          priority if (!op_ok) begin
            state <= S_IDLE;
          end else if (alu_req.start) begin
            state <= S_BUSY;
          end else begin
            t_reg <= x_reg;
            state <= S_COMMIT;
          end
        end
        S_BUSY: begin
          if (alu_done) begin
            t_reg <= alu_y;
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          priority if (op_term) begin
            product_term <= t_reg;
            pend         <= (op_reg == OP_MUL) ? PEND_MUL : PEND_DIV;
            state        <= S_IDLE;
          end else if (op_reg == OP_EQ) begin
            // Start over once the total has gone to the output word
            if (out_free) begin
              running_sum  <= '0;
              add_neg      <= 1'b0;
              product_term <= '0;
              pend         <= PEND_NONE;
              state        <= S_IDLE;
            end
          end else begin
            running_sum  <= sum_next;
            add_neg      <= (op_reg == OP_SUB);
            product_term <= '0;
            pend         <= PEND_NONE;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/iee_checker.sv -----
// Port-level checks for the expression evaluator, bound to the top level.
`default_nettype none
module iee_checker #(
  parameter int DATA_WIDTH = 32
) (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  s_tvalid,
  input wire logic                                  s_tready,
  input wire logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  input wire logic [2:0]                            s_tuser,
  input wire logic                                  m_tvalid,
  input wire logic                                  m_tready,
  input wire logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);
  import iee_pkg::*;

  // Stalled output word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  // Stalled output word keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output word changed while stalled");

  // One word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // Only '=' makes an output word
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && s_tvalid && s_tready && (s_tuser != OP_EQ) |=> !m_tvalid)
    else $error("output word without equals");

  // Reset clears the output
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind infix_integer_expression_evaluator iee_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_iee_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
